// ===== rtl/core/srrip_pkg.sv =====
// ----------------------------------------------------------------------------
// srrip_pkg
// Shared types and constants for the signature RRIP replacement core.
// ----------------------------------------------------------------------------
`default_nettype none

package srrip_pkg;

    // Default geometry
    localparam int DEF_NUM_SETS       = 2048;
    localparam int DEF_NUM_WAYS       = 16;
    localparam int DEF_SIG_INDEX_BITS = 12;

    // Fixed field widths
    localparam int SET_IN_W  = 11;
    localparam int WAY_IN_W  = 4;
    localparam int ADDR_W    = 64;
    localparam int CONF_W    = 8;
    localparam int CNT_W     = 4;
    localparam int RRPV_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;

    // Value limits and reset values
    localparam logic [RRPV_W-1:0] RRPV_MAX   = 2'd3;
    localparam logic [RRPV_W-1:0] RRPV_NEAR  = 2'd1;
    localparam logic [RRPV_W-1:0] RRPV_MRU   = 2'd0;
    localparam logic [CNT_W-1:0]  SIG_SAT    = 4'd15;
    localparam logic [CNT_W-1:0]  SIG_RESET  = 4'd3;
    localparam logic [CONF_W-1:0] CONF_SAT   = 8'd255;

    // Hash shift amounts
    localparam int HASH_SHIFT_A = 13;
    localparam int HASH_SHIFT_B = 23;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STREAM_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOT_THR    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WARM_THR   = 2'd2;

    // Reset values of configuration registers
    localparam logic [CONF_W-1:0] STREAM_THR_RST = 8'd4;
    localparam logic [CNT_W-1:0]  HOT_THR_RST    = 4'd7;
    localparam logic [CNT_W-1:0]  WARM_THR_RST   = 4'd3;

    // Operation codes
    localparam logic OP_VICTIM = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MODQ,
        ST_MODR,
        ST_READ,
        ST_EXEC,
        ST_DONE
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic clr_step;
        logic load;
        logic mod_q;
        logic mod_r;
        logic rd;
        logic ex;
        logic wb;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/srrip_ctrl.sv =====
// ----------------------------------------------------------------------------
// srrip_ctrl
// Sequencer: clearing pass after reset, then one item at a time through
// set reduction, memory read, execute and write back.
// ----------------------------------------------------------------------------
`default_nettype none

module srrip_ctrl
    import srrip_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  dp_status_t      status,
    output dp_cmd_t         cmd
);

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (status.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_MODQ;
                end
            end
            ST_MODQ: begin
                cmd.mod_q  = 1'b1;
                state_next = ST_MODR;
            end
            ST_MODR: begin
                cmd.mod_r  = 1'b1;
                state_next = ST_READ;
            end
            ST_READ: begin
                cmd.rd     = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                cmd.ex     = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // hold until the output register can take the item
                if (status.out_free) begin
                    cmd.wb     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/srrip_dp.sv =====
// ----------------------------------------------------------------------------
// srrip_dp
// Datapath: input registers, set reduction, RRPV / signature / stride
// memories, victim search, insertion decision and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module srrip_dp
    import srrip_pkg::*;
#(
    parameter int NUM_SETS       = DEF_NUM_SETS,
    parameter int NUM_WAYS       = DEF_NUM_WAYS,
    parameter int SIG_INDEX_BITS = DEF_SIG_INDEX_BITS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  dp_cmd_t                    cmd,
    output dp_status_t                 status,
    input  wire logic                  in_op,
    input  wire logic [SET_IN_W-1:0]   in_set_index,
    input  wire logic [WAY_IN_W-1:0]   in_way_index,
    input  wire logic [ADDR_W-1:0]     in_pc,
    input  wire logic [ADDR_W-1:0]     in_phys_addr,
    input  wire logic                  in_was_hit,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DAT_W-1:0]  cfg_wdata,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [WAY_IN_W-1:0]        out_victim_way,
    output logic [RRPV_W-1:0]          out_inserted_rrpv,
    output logic                       out_stream_seen
);

    localparam int SET_W   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_W   = $clog2(NUM_WAYS);
    localparam int SIG_W   = SIG_INDEX_BITS;
    localparam int SIG_N   = 1 << SIG_INDEX_BITS;
    localparam int CLR_N   = (NUM_SETS > SIG_N) ? NUM_SETS : SIG_N;
    localparam int CLR_W   = $clog2(CLR_N);
    localparam int ROW_W   = NUM_WAYS * RRPV_W;
    localparam int SROW_W  = 2 * ADDR_W + CONF_W;
    localparam int RECIP_W = 33;
    localparam int PROD_W  = SET_IN_W + RECIP_W;
    localparam int QN_W    = 28;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << 32) + 64'(NUM_SETS) - 64'd1) / 64'(NUM_SETS));

    // Memories
    logic [ROW_W-1:0]  rrpv_mem [NUM_SETS];
    logic [CNT_W-1:0]  sig_mem  [SIG_N];
    logic [SROW_W-1:0] set_mem  [NUM_SETS];

    // Configuration registers
    logic [CONF_W-1:0] stream_thr_reg;
    logic [CNT_W-1:0]  hot_thr_reg;
    logic [CNT_W-1:0]  warm_thr_reg;

    // Item registers
    logic                 op_reg;
    logic [SET_IN_W-1:0]  set_raw_reg;
    logic [WAY_IN_W-1:0]  way_reg;
    logic [SIG_W-1:0]     sig_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic                 hit_reg;
    logic [SET_IN_W-1:0]  q_reg;
    logic [SET_W-1:0]     set_reg;
    logic [ADDR_W-1:0]    delta_reg;
    logic                 same_reg;

    // Memory read data
    logic [ROW_W-1:0]  row_q;
    logic [CNT_W-1:0]  sig_q;
    logic [SROW_W-1:0] srow_q;

    // Clear counter
    logic [CLR_W-1:0] clr_cnt_reg;

    // Output registers
    logic                out_valid_reg;
    logic [WAY_IN_W-1:0] victim_reg;
    logic [RRPV_W-1:0]   ins_reg;
    logic                stream_reg;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stream_thr_reg <= STREAM_THR_RST;
            hot_thr_reg    <= HOT_THR_RST;
            warm_thr_reg   <= WARM_THR_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_STREAM_THR: stream_thr_reg <= cfg_wdata;
                CFG_HOT_THR:    hot_thr_reg    <= cfg_wdata[CNT_W-1:0];
                CFG_WARM_THR:   warm_thr_reg   <= cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Advance the clearing pass
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    assign status.clr_last = (32'(clr_cnt_reg) == CLR_N - 1);

    // Capture the item and hash the PC
    logic [ADDR_W-1:0] pc_hash;
    assign pc_hash = in_pc ^ (in_pc >> HASH_SHIFT_A) ^ (in_pc >> HASH_SHIFT_B);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg      <= in_op;
            set_raw_reg <= in_set_index;
            way_reg     <= in_way_index;
            sig_reg     <= pc_hash[SIG_W-1:0];
            addr_reg    <= in_phys_addr;
            hit_reg     <= in_was_hit;
        end
    end

    // Reduce the set index modulo NUM_SETS by reciprocal multiply
    logic [PROD_W-1:0] prod;
    logic [QN_W-1:0]   qn;
    logic [QN_W-1:0]   rem;
    assign prod = PROD_W'(set_raw_reg) * PROD_W'(RECIP);
    assign qn   = QN_W'(q_reg) * QN_W'(NUM_SETS);
    assign rem  = QN_W'(set_raw_reg) - qn;

    always_ff @(posedge aclk) begin
        if (cmd.mod_q) begin
            q_reg <= prod[32 +: SET_IN_W];
        end
        if (cmd.mod_r) begin
            set_reg <= rem[SET_W-1:0];
        end
    end

    // Stride fields of the set row
    logic [ADDR_W-1:0] last_addr;
    logic [ADDR_W-1:0] last_delta;
    logic [CONF_W-1:0] conf_old;
    logic [ADDR_W-1:0] delta;
    assign last_addr  = srow_q[SROW_W-1 -: ADDR_W];
    assign last_delta = srow_q[CONF_W +: ADDR_W];
    assign conf_old   = srow_q[CONF_W-1:0];
    assign delta      = (last_addr != '0) ? (addr_reg - last_addr) : '0;

    always_ff @(posedge aclk) begin
        if (cmd.ex) begin
            delta_reg <= delta;
            same_reg  <= (delta != '0) && (delta == last_delta);
        end
    end

    // Victim search: highest value present, first way holding it
    logic              any3, any2, any1;
    logic [RRPV_W-1:0] top;
    logic [RRPV_W-1:0] age;
    logic [WAY_W-1:0]  pick;
    logic [ROW_W-1:0]  aged_row;

    always_comb begin
        any3 = 1'b0;
        any2 = 1'b0;
        any1 = 1'b0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            any3 |= (row_q[w*RRPV_W +: RRPV_W] == 2'd3);
            any2 |= (row_q[w*RRPV_W +: RRPV_W] == 2'd2);
            any1 |= (row_q[w*RRPV_W +: RRPV_W] == 2'd1);
        end
        top = any3 ? 2'd3 : (any2 ? 2'd2 : (any1 ? 2'd1 : 2'd0));
        age = RRPV_MAX - top;
        pick = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (row_q[w*RRPV_W +: RRPV_W] == top) begin
                pick = WAY_W'(w);
            end
        end
        for (int w = 0; w < NUM_WAYS; w++) begin
            aged_row[w*RRPV_W +: RRPV_W] = row_q[w*RRPV_W +: RRPV_W] + age;
        end
    end

    // Insertion decision and counter updates
    logic [CONF_W-1:0] conf_new;
    logic              streaming;
    logic [RRPV_W-1:0] ins;
    logic [CNT_W-1:0]  sig_new;
    logic [ROW_W-1:0]  upd_row;

    always_comb begin
        conf_new  = same_reg ? ((conf_old < CONF_SAT) ? conf_old + 1'b1 : conf_old) : '0;
        streaming = !hit_reg && (conf_new >= stream_thr_reg);
        if (hit_reg) begin
            ins     = RRPV_MRU;
            sig_new = (sig_q < SIG_SAT) ? sig_q + 1'b1 : sig_q;
        end else begin
            if (streaming) begin
                ins = RRPV_MAX;
            end else if (sig_q >= hot_thr_reg) begin
                ins = RRPV_MRU;
            end else if (sig_q >= warm_thr_reg) begin
                ins = RRPV_NEAR;
            end else begin
                ins = RRPV_MAX;
            end
            sig_new = (sig_q > hot_thr_reg) ? sig_q - 1'b1 : sig_q;
        end
        for (int w = 0; w < NUM_WAYS; w++) begin
            upd_row[w*RRPV_W +: RRPV_W] =
                (32'(way_reg) == w) ? ins : row_q[w*RRPV_W +: RRPV_W];
        end
    end

    // Memory port controls
    logic              rrpv_we, sig_we, set_we;
    logic [SET_W-1:0]  rrpv_wa;
    logic [SIG_W-1:0]  sig_wa;
    logic [ROW_W-1:0]  rrpv_wd;
    logic [CNT_W-1:0]  sig_wd;
    logic [SROW_W-1:0] set_wd;

    always_comb begin
        if (cmd.clr_step) begin
            rrpv_we = (32'(clr_cnt_reg) < NUM_SETS);
            set_we  = rrpv_we;
            sig_we  = (32'(clr_cnt_reg) < SIG_N);
            rrpv_wa = clr_cnt_reg[SET_W-1:0];
            sig_wa  = clr_cnt_reg[SIG_W-1:0];
            rrpv_wd = {NUM_WAYS{RRPV_MAX}};
            sig_wd  = SIG_RESET;
            set_wd  = '0;
        end else begin
            rrpv_we = cmd.wb;
            set_we  = cmd.wb && (op_reg == OP_UPDATE) && !hit_reg;
            sig_we  = cmd.wb && (op_reg == OP_UPDATE);
            rrpv_wa = set_reg;
            sig_wa  = sig_reg;
            rrpv_wd = (op_reg == OP_VICTIM) ? aged_row : upd_row;
            sig_wd  = sig_new;
            set_wd  = {addr_reg, delta_reg, conf_new};
        end
    end

    // RRPV rows
    always_ff @(posedge aclk) begin
        if (rrpv_we) begin
            rrpv_mem[rrpv_wa] <= rrpv_wd;
        end
        if (cmd.rd) begin
            row_q <= rrpv_mem[set_reg];
        end
    end

    // Signature counters
    always_ff @(posedge aclk) begin
        if (sig_we) begin
            sig_mem[sig_wa] <= sig_wd;
        end
        if (cmd.rd) begin
            sig_q <= sig_mem[sig_reg];
        end
    end

    // Per-set stride state
    always_ff @(posedge aclk) begin
        if (set_we) begin
            set_mem[rrpv_wa] <= set_wd;
        end
        if (cmd.rd) begin
            srow_q <= set_mem[set_reg];
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.wb) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wb) begin
            if (op_reg == OP_VICTIM) begin
                victim_reg <= WAY_IN_W'(pick);
                ins_reg    <= '0;
                stream_reg <= 1'b0;
            end else begin
                victim_reg <= '0;
                ins_reg    <= ins;
                stream_reg <= streaming;
            end
        end
    end

    assign status.out_free  = !out_valid_reg || out_ready;
    assign out_valid         = out_valid_reg;
    assign out_victim_way    = victim_reg;
    assign out_inserted_rrpv = ins_reg;
    assign out_stream_seen   = stream_reg;

endmodule

`default_nettype wire

// ===== rtl/core/signature_rrip_replacement_core.sv =====
// ----------------------------------------------------------------------------
// signature_rrip_replacement_core
// Signature-guided RRIP replacement policy with per-set stream detection.
// ----------------------------------------------------------------------------
// After reset the core runs a clearing pass over max(NUM_SETS, 2^SIG_INDEX_BITS)
// entries (4096 with defaults) with s_ready low; configuration writes are taken
// meanwhile. Each item then passes from acceptance to its result in the output
// register through the set-index reduction (multiply, then subtract), the memory
// read, the address delta compare, and victim search or insertion with write
// back. s_ready rises again in the next cycle, so a new item is accepted only
// once the previous one has been written back. A result still waiting on m_ready
// stalls the next item just before its write back.
// Configuration may be written only while no item is in flight.
`default_nettype none

module signature_rrip_replacement_core
    import srrip_pkg::*;
#(
    parameter int NUM_SETS       = DEF_NUM_SETS,
    parameter int NUM_WAYS       = DEF_NUM_WAYS,
    parameter int SIG_INDEX_BITS = DEF_SIG_INDEX_BITS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_op,
    input  wire logic [SET_IN_W-1:0]   s_set_index,
    input  wire logic [WAY_IN_W-1:0]   s_way_index,
    input  wire logic [ADDR_W-1:0]     s_pc,
    input  wire logic [ADDR_W-1:0]     s_phys_addr,
    input  wire logic                  s_was_hit,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [WAY_IN_W-1:0]        m_victim_way,
    output logic [RRPV_W-1:0]          m_inserted_rrpv,
    output logic                       m_stream_seen,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DAT_W-1:0]  cfg_wdata
);

    dp_cmd_t    cmd;
    dp_status_t status;

    srrip_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .status   (status),
        .cmd      (cmd)
    );

    srrip_dp #(
        .NUM_SETS       (NUM_SETS),
        .NUM_WAYS       (NUM_WAYS),
        .SIG_INDEX_BITS (SIG_INDEX_BITS)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .in_op             (s_op),
        .in_set_index      (s_set_index),
        .in_way_index      (s_way_index),
        .in_pc             (s_pc),
        .in_phys_addr      (s_phys_addr),
        .in_was_hit        (s_was_hit),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .out_valid         (m_valid),
        .out_ready         (m_ready),
        .out_victim_way    (m_victim_way),
        .out_inserted_rrpv (m_inserted_rrpv),
        .out_stream_seen   (m_stream_seen)
    );

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the signature RRIP replacement core: a behavioral
// copy of the policy predicts every result, bursty stimulus and a stalling
// receiver exercise the handshakes, and thresholds are swept between phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import srrip_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETS      = DEF_NUM_SETS;
    localparam int WAYS      = DEF_NUM_WAYS;
    localparam int SIG_IDX_W = DEF_SIG_INDEX_BITS;
    localparam int SIG_COUNT = 1 << SIG_IDX_W;
    localparam int LIMIT     = 2000000;
    localparam int SETTLE    = 20;

    typedef struct packed {
        logic [WAY_IN_W-1:0] victim;
        logic [RRPV_W-1:0]   rrpv;
        logic                stream;
    } outcome_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_op;
    logic [SET_IN_W-1:0]  s_set_index;
    logic [WAY_IN_W-1:0]  s_way_index;
    logic [ADDR_W-1:0]    s_pc;
    logic [ADDR_W-1:0]    s_phys_addr;
    logic                 s_was_hit;
    logic                 m_valid;
    logic                 m_ready;
    logic [WAY_IN_W-1:0]  m_victim_way;
    logic [RRPV_W-1:0]    m_inserted_rrpv;
    logic                 m_stream_seen;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_wdata;

    // Policy copy
    logic [RRPV_W-1:0] rrpv_mem [SETS][WAYS];
    logic [CNT_W-1:0]  sig_ctr  [SIG_COUNT];
    logic [ADDR_W-1:0] prev_addr  [SETS];
    logic [ADDR_W-1:0] prev_delta [SETS];
    logic [CONF_W-1:0] confidence [SETS];
    logic [CONF_W-1:0] stream_thr;
    logic [CNT_W-1:0]  hot_thr;
    logic [CNT_W-1:0]  warm_thr;

    outcome_t pending_outcomes [$];
    int       mismatches;
    int       cycles;
    bit       hold_off;
    bit       stall_mode;

    signature_rrip_replacement_core dut (.*);

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [SIG_IDX_W-1:0] pc_signature(logic [ADDR_W-1:0] pc);
        logic [ADDR_W-1:0] h;
        h = pc ^ (pc >> HASH_SHIFT_A) ^ (pc >> HASH_SHIFT_B);
        return h[SIG_IDX_W-1:0];
    endfunction

    // Apply one item to the policy copy and return its outcome
    function automatic outcome_t apply_access(logic op, logic [SET_IN_W-1:0] set_in,
                                              logic [WAY_IN_W-1:0] way,
                                              logic [ADDR_W-1:0] pc,
                                              logic [ADDR_W-1:0] addr, logic hit);
        outcome_t r;
        int s;
        int sg;
        logic [RRPV_W-1:0] top;
        logic [ADDR_W-1:0] delta;
        logic [CNT_W-1:0] strength;
        r = '0;
        s = set_in % SETS;
        sg = pc_signature(pc);
        if (op == OP_VICTIM) begin
            top = '0;
            for (int w = 0; w < WAYS; w++)
                if (rrpv_mem[s][w] > top) begin
                    top = rrpv_mem[s][w];
                    r.victim = w[WAY_IN_W-1:0];
                end
            if (top < RRPV_MAX)
                for (int w = 0; w < WAYS; w++)
                    rrpv_mem[s][w] = rrpv_mem[s][w] + (RRPV_MAX - top);
            return r;
        end
        if (hit) begin
            r.rrpv = RRPV_MRU;
            if (sig_ctr[sg] < SIG_SAT) sig_ctr[sg] = sig_ctr[sg] + 1'b1;
        end else begin
            delta = (prev_addr[s] != 0) ? addr - prev_addr[s] : '0;
            strength = sig_ctr[sg];
            if (delta != 0 && delta == prev_delta[s]) begin
                if (confidence[s] < CONF_SAT) confidence[s] = confidence[s] + 1'b1;
            end else begin
                confidence[s] = '0;
            end
            prev_delta[s] = delta;
            prev_addr[s] = addr;
            r.stream = confidence[s] >= stream_thr;
            if (r.stream) r.rrpv = RRPV_MAX;
            else if (strength >= hot_thr) r.rrpv = RRPV_MRU;
            else if (strength >= warm_thr) r.rrpv = RRPV_NEAR;
            else r.rrpv = RRPV_MAX;
            if (strength > hot_thr && strength > 0) sig_ctr[sg] = strength - 1'b1;
        end
        if (way < WAYS) rrpv_mem[s][way] = r.rrpv;
        return r;
    endfunction

    // Receiver: stall pattern, or long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_off) begin
            m_ready <= 1'b0;
        end else if (stall_mode) begin
            m_ready <= ($urandom_range(0, 3) != 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Check each accepted result against the oldest expectation
    always @(posedge aclk) begin
        outcome_t want;
        outcome_t got;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_victim_way, m_inserted_rrpv, m_stream_seen};
            if (pending_outcomes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
                want = pending_outcomes.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p got %p", want, got);
                end
            end
        end
    end

    // Send one item; the prediction is queued at acceptance. Valid stays up
    // so that a following item can go back to back; idle_input drops it.
    task automatic send_access(logic op, logic [SET_IN_W-1:0] set_in,
                               logic [WAY_IN_W-1:0] way, logic [ADDR_W-1:0] pc,
                               logic [ADDR_W-1:0] addr, logic hit);
        s_valid     <= 1'b1;
        s_op        <= op;
        s_set_index <= set_in;
        s_way_index <= way;
        s_pc        <= pc;
        s_phys_addr <= addr;
        s_was_hit   <= hit;
        do @(posedge aclk); while (!s_ready);
        pending_outcomes.push_back(apply_access(op, set_in, way, pc, addr, hit));
    endtask

    // Drop valid after the last accepted item
    task automatic idle_input();
        s_valid <= 1'b0;
    endtask

    // Random gap between bursts
    task automatic maybe_gap();
        if ($urandom_range(0, 7) == 0) begin
            idle_input();
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        idle_input();
        while (pending_outcomes.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        if (idx == CFG_STREAM_THR) stream_thr = val;
        else if (idx == CFG_HOT_THR) hot_thr = val[CNT_W-1:0];
        else if (idx == CFG_WARM_THR) warm_thr = val[CNT_W-1:0];
    endtask

    task automatic set_thresholds(logic [7:0] st, logic [3:0] ht, logic [3:0] wt);
        drain();
        write_cfg(CFG_STREAM_THR, st);
        write_cfg(CFG_HOT_THR, {4'd0, ht});
        write_cfg(CFG_WARM_THR, {4'd0, wt});
        cfg_we <= 1'b0;
    endtask

    function automatic logic [ADDR_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Extremes, both operations, aging and streaming cases
    task automatic test_directed();
        logic [ADDR_W-1:0] base;
        send_access(OP_VICTIM, 11'd0, 4'd0, '0, '0, 1'b0);
        send_access(OP_UPDATE, 11'd0, 4'd15, '1, '1, 1'b1);
        send_access(OP_UPDATE, 11'd2047, 4'd0, '0, 64'h1000, 1'b0);
        send_access(OP_UPDATE, 11'd0, 4'd3, 64'h1234_5678, '0, 1'b1);
        // Age a set whose ways are all promoted
        for (int w = 0; w < WAYS; w++)
            send_access(OP_UPDATE, 11'd5, w[3:0], '1, '1, 1'b1);
        send_access(OP_VICTIM, 11'd5, 4'd0, '0, '0, 1'b0);
        send_access(OP_VICTIM, 11'd2047, 4'd9, '1, '1, 1'b1);
        // Constant stride reaches the stream threshold
        base = 64'h8000_0000_0000_0040;
        for (int i = 0; i < 7; i++)
            send_access(OP_UPDATE, 11'd7, 4'd1, 64'h40, base + 64'(i) * 64'd64, 1'b0);
        send_access(OP_UPDATE, 11'd7, 4'd2, 64'h40, base - 64'd3, 1'b0);
    endtask

    // Repeated hits saturate a signature; misses decay it
    task automatic test_signature_strength();
        for (int i = 0; i < 16; i++)
            send_access(OP_UPDATE, 11'd9, 4'd4, 64'hABCD, rand64(), 1'b1);
        for (int i = 0; i < 10; i++)
            send_access(OP_UPDATE, 11'd9, 4'd4, 64'hABCD, rand64(), 1'b0);
    endtask

    // Random mix: mostly strided miss runs on few sets, plus noise
    task automatic test_random(int count);
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] stride;
        logic [ADDR_W-1:0] pc;
        logic [SET_IN_W-1:0] set_in;
        int n;
        int run;
        n = 0;
        while (n < count) begin
            set_in = ($urandom_range(0, 3) == 0) ? SET_IN_W'($urandom)
                                                 : SET_IN_W'($urandom_range(0, 15));
            pc = ($urandom_range(0, 1) != 0) ? {52'd0, 12'($urandom_range(0, 31))}
                                            : rand64();
            case ($urandom_range(0, 3))
                0: begin
                    addr = rand64();
                    stride = 64'($urandom_range(1, 8)) << 6;
                    run = $urandom_range(2, 12);
                    for (int i = 0; i < run; i++) begin
                        send_access(OP_UPDATE, set_in, WAY_IN_W'($urandom), pc, addr, 1'b0);
                        addr = addr + stride;
                        maybe_gap();
                    end
                    n += run;
                end
                1: begin
                    send_access(OP_VICTIM, set_in, WAY_IN_W'($urandom), rand64(), rand64(),
                                1'($urandom));
                    n++;
                end
                default: begin
                    send_access(OP_UPDATE, set_in, WAY_IN_W'($urandom), pc, rand64(),
                                1'($urandom));
                    n++;
                end
            endcase
            maybe_gap();
        end
    endtask

    // Receiver holds off while the sender keeps offering items
    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (200) @(posedge aclk);
                hold_off = 1'b0;
            end
            test_random(60);
        join
        drain();
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0; s_op = 1'b0; s_set_index = '0; s_way_index = '0;
        s_pc = '0; s_phys_addr = '0; s_was_hit = 1'b0;
        cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
        hold_off = 1'b0; stall_mode = 1'b0;
        mismatches = 0; cycles = 0;
        for (int s = 0; s < SETS; s++) begin
            for (int w = 0; w < WAYS; w++) rrpv_mem[s][w] = RRPV_MAX;
            prev_addr[s] = '0; prev_delta[s] = '0; confidence[s] = '0;
        end
        for (int i = 0; i < SIG_COUNT; i++) sig_ctr[i] = SIG_RESET;
        stream_thr = STREAM_THR_RST; hot_thr = HOT_THR_RST; warm_thr = WARM_THR_RST;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_signature_strength();
        stall_mode = 1'b1;
        test_random(400);
        test_backpressure();
        set_thresholds(8'd1, 4'd0, 4'd0);
        test_random(400);
        set_thresholds(8'd255, 4'd15, 4'd15);
        test_signature_strength();
        test_random(400);
        stall_mode = 1'b0;
        set_thresholds(8'd0, 4'd9, 4'd2);
        test_random(400);
        set_thresholds(8'd3, 4'd5, 4'd12);
        stall_mode = 1'b1;
        test_random(400);
        drain();

        if (mismatches == 0 && pending_outcomes.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

`default_nettype wire
